// ===== hw/rtl/snct_pkg.sv =====
package snct_pkg;

  // field widths fixed by the item format
  localparam int Q_W     = 16;
  localparam int COORD_W = 8;
  localparam int PROD_W  = 2 * Q_W;
  // sum bit that carries the +/-8.0 boundary in Q8.24
  localparam int SAT_BIT = 27;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_DELIVER = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  // input word
  typedef struct packed {
    func_t                     func;
    logic [COORD_W-1:0]        src_x;
    logic [COORD_W-1:0]        src_y;
    logic signed [Q_W-1:0]     value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [Q_W-1:0] neuron_out;
    logic           status;
  } out_word_t;

  // one connection entry as stored in the table memory
  typedef struct packed {
    logic [COORD_W-1:0]    src_x;
    logic [COORD_W-1:0]    src_y;
    logic signed [Q_W-1:0] weight;
    logic signed [Q_W-1:0] value;
  } conn_t;

  localparam int CONN_W = $bits(conn_t);

  // controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic lookup;
  } mac_ctrl_t;

  typedef logic [255:0][Q_W-1:0] sig_tab_t;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(a*b / 2^62)
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // round(65535*sigmoid(k/16-8)) for k = 0..255
  function automatic sig_tab_t sigmoid_table();
    logic [128:0][63:0] e_pow;
    logic [63:0]        step;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        e40;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        q;
    logic [7:0]         mm;
    sig_tab_t           tab;
    step = '0;
    term = Q62_ONE;
    // exp(-1/16) by its series
    for (int n = 0; n < 24; n++) begin
      if (n > 0) term = udiv64(term, 64'(16 * n));
      if ((n % 2) == 1) step = step - term;
      else              step = step + term;
    end
    e = Q62_ONE;
    e_pow[0] = e;
    for (int m = 1; m <= 128; m++) begin
      e = mul_q62(e, step);
      e_pow[8'(m)] = e;
    end
    for (int k = 0; k < 256; k++) begin
      mm  = (k < 128) ? 8'(128 - k) : 8'(k - 128);
      e40 = e_pow[mm] >> 22;
      den = (64'd1 << 40) + e40;
      num = (k < 128) ? 64'd65535 * e40 : 64'd65535 << 40;
      q   = udiv64(2 * num + den, 2 * den);
      tab[8'(k)] = q[Q_W-1:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIGMOID_TAB = sigmoid_table();

endpackage

// ===== hw/rtl/snct_ram.sv =====
module snct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/snct_mac.sv =====
module snct_mac import snct_pkg::*; #(
  parameter int SUM_W = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mac_ctrl_t             ctrl,
  input  logic signed [Q_W-1:0] weight,
  input  logic signed [Q_W-1:0] value,
  output logic [Q_W-1:0]        activation
);

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic                     in_range;
  logic [7:0]               tab_idx;

  // product register, then accumulator
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= weight * value;
    end
    if (ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.acc_en) begin
      sum <= sum + SUM_W'(prod);
    end
  end

  // saturate to [-8,8) and take the 1/16 step index
  always_comb begin
    in_range = (&sum[SUM_W-1:SAT_BIT]) || !(|sum[SUM_W-1:SAT_BIT]);
    if (in_range) begin
      tab_idx = {~sum[SAT_BIT], sum[SAT_BIT-1:SAT_BIT-7]};
    end else if (sum[SUM_W-1]) begin
      tab_idx = 8'h00;
    end else begin
      tab_idx = 8'hFF;
    end
  end

  // last activation
  always_ff @(posedge clk) begin
    if (rst) begin
      activation <= '0;
    end else if (ctrl.lookup) begin
      activation <= SIGMOID_TAB[tab_idx];
    end
  end

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> sum == '0)
    else $error("accumulator not cleared");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    ctrl.acc_en |-> $past(ctrl.mul_en))
    else $error("accumulate without a product");

  a_lookup_quiet: assert property (@(posedge clk) disable iff (rst)
    ctrl.lookup |-> !ctrl.mul_en && !ctrl.acc_en && !ctrl.clear)
    else $error("lookup while sum still moving");

endmodule

// ===== hw/rtl/sigmoid_neuron_connection_table.sv =====
// Sigmoid neuron with a connection table.
// Input words arrive on item_valid/item_stall/item; one result word per input
// word leaves on result_valid/result_stall/result. A word moves at a clock edge
// where valid is high and stall is low.
// Load appends a connection (or reports status 1 when the table is full),
// deliver writes the value as input of every connection with a matching source,
// compute forms sum(input*weight), saturates it and looks up the sigmoid.
// Every result carries the last computed output.
// The connections live in one memory with a single registered read port, so
// deliver and compute read one entry per cycle: they walk the stored
// connections, drain the read and product registers and, for compute, look up
// the sigmoid before the result word is written; load and the unused code go
// straight to the result. One word is in work at a time; the next is taken
// once the current result sits in the output register, even while the
// receiver stalls it.
// A stalled result stays in the output register; the block finishes its work
// and waits before writing the next result over it.
// Reset empties the table (count zero) and zeroes the last output; it needs no
// memory clearing pass, since entries at or above the count are never read.
module sigmoid_neuron_connection_table import snct_pkg::*; #(
  parameter int MAX_CONNECTIONS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result
);

  localparam int AW    = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
  localparam int CW    = $clog2(MAX_CONNECTIONS + 1);
  localparam int SUM_W = PROD_W + 1 + AW;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_CONNECTIONS);

  state_t          state, state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [AW-1:0]   rd_addr;
  logic            rd_vld;
  logic            prod_vld;
  logic            status;
  in_word_t        cur;
  logic            accept;
  logic            issue;
  logic            emit;
  logic            load_ok;
  logic            match;
  mac_ctrl_t       ctrl;
  logic            we;
  logic [AW-1:0]   waddr;
  conn_t           wdata;
  conn_t           rdata;
  logic [Q_W-1:0]  activation;

  assign accept  = item_valid && !item_stall;
  assign load_ok = (item.func == FUNC_LOAD) && (count != MAX_COUNT);
  assign match   = (rdata.src_x == cur.src_x) && (rdata.src_y == cur.src_y);

  // next state and sequencing
  always_comb begin
    state_next  = state;
    item_stall  = 1'b1;
    issue       = 1'b0;
    emit        = 1'b0;
    ctrl        = '0;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          ctrl.clear = 1'b1;
          unique case (item.func)
            FUNC_LOAD, FUNC_NOP:       state_next = ST_FINISH;
            FUNC_DELIVER, FUNC_COMPUTE: state_next = ST_WALK;
          endcase
        end
      end
      ST_WALK: begin
        if (idx != count) begin
          issue = 1'b1;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !prod_vld) begin
          state_next = (cur.func == FUNC_COMPUTE) ? ST_LOOKUP : ST_FINISH;
        end
      end
      ST_LOOKUP: begin
        ctrl.lookup = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    ctrl.mul_en = rd_vld && (cur.func == FUNC_COMPUTE);
    ctrl.acc_en = prod_vld;
  end

  // memory write: append on load, write back matching entries on deliver
  always_comb begin
    if (rd_vld) begin
      we    = (cur.func == FUNC_DELIVER) && match;
      waddr = rd_addr;
      wdata = '{src_x: rdata.src_x, src_y: rdata.src_y,
                weight: rdata.weight, value: cur.value};
    end else begin
      we    = accept && load_ok;
      waddr = count[AW-1:0];
      wdata = '{src_x: item.src_x, src_y: item.src_y,
                weight: item.value, value: '0};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      rd_vld       <= 1'b0;
      prod_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= issue;
      prod_vld <= ctrl.mul_en;
      if (accept && load_ok) begin
        count <= count + 1'b1;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur    <= item;
      idx    <= '0;
      status <= (item.func == FUNC_LOAD) && (count == MAX_COUNT);
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
    if (issue) begin
      rd_addr <= idx[AW-1:0];
    end
    if (emit) begin
      result.neuron_out <= activation;
      result.status     <= status;
    end
  end

  // read one entry, write back one behind: the two addresses never collide
  snct_ram #(
    .WIDTH (CONN_W),
    .DEPTH (MAX_CONNECTIONS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  snct_mac #(
    .SUM_W (SUM_W)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .weight     (rdata.weight),
    .value      (rdata.value),
    .activation (activation)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT)
    else $error("connection count past table depth");

  a_read_written: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> CW'(rd_addr) < count)
    else $error("read of an entry never written");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !rd_vld && !prod_vld)
    else $error("walk pipeline busy while idle");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && item.func == FUNC_LOAD && count == MAX_COUNT)
      |=> count == MAX_COUNT && status)
    else $error("load into full table not dropped");

endmodule

// ===== verif/snct_predict_check.sv =====
module snct_predict_check import snct_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_stall,
  input  in_word_t  item,
  input  logic      result_valid,
  input  logic      result_stall,
  input  out_word_t result,
  output int        mismatches,
  output int        outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  // saturation bound of the Q8.24 sum, +/-8.0
  localparam longint SUM_LIM = longint'(1) << 27;

  typedef struct packed {
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic signed [Q_W-1:0] weight;
    logic signed [Q_W-1:0] level;
  } link_t;

  logic [Q_W-1:0] sigmoid_lut [256];
  link_t          links [DEPTH];
  int             link_count;
  logic [Q_W-1:0] activation;
  out_word_t      expected_q [$];
  int             fail_total;

  // build the sigmoid lookup: exp(-1/16) by its series, then its powers
  initial begin
    logic [63:0]  step;
    logic [63:0]  term;
    logic [63:0]  e40;
    logic [63:0]  den;
    logic [63:0]  num;
    logic [63:0]  pow [129];
    logic [127:0] prod;
    int           span;
    fail_total  = 0;
    link_count  = 0;
    activation  = '0;
    step = '0;
    term = 64'd1 << 62;
    for (int n = 0; n < 24; n++) begin
      if (n > 0) term = term / (64'd16 * 64'(n));
      if (n % 2 == 1) step = step - term;
      else step = step + term;
    end
    pow[0] = 64'd1 << 62;
    for (int m = 1; m <= 128; m++) begin
      prod   = {64'd0, pow[m-1]} * {64'd0, step};
      pow[m] = prod[125:62];
    end
    for (int k = 0; k < 256; k++) begin
      span = (k < 128) ? 128 - k : k - 128;
      e40  = pow[span] >> 22;
      den  = (64'd1 << 40) + e40;
      num  = (k < 128) ? 64'd65535 * e40 : 64'd65535 << 40;
      sigmoid_lut[k] = 16'((2 * num + den) / (2 * den));
    end
  end

  // apply one input word to the neuron state and form its result word
  function automatic out_word_t neuron_step(input in_word_t w);
    out_word_t r;
    longint    acc;
    r.status = 1'b0;
    case (w.func)
      FUNC_LOAD: begin
        if (link_count < DEPTH) begin
          links[link_count] = '{x: w.src_x, y: w.src_y, weight: w.value, level: '0};
          link_count++;
        end else begin
          r.status = 1'b1;
        end
      end
      FUNC_DELIVER: begin
        for (int i = 0; i < link_count; i++)
          if (links[i].x == w.src_x && links[i].y == w.src_y) links[i].level = w.value;
      end
      FUNC_COMPUTE: begin
        acc = 0;
        for (int i = 0; i < link_count; i++)
          acc += longint'(links[i].level) * longint'(links[i].weight);
        if (acc < -SUM_LIM) acc = -SUM_LIM;
        if (acc > SUM_LIM - 1) acc = SUM_LIM - 1;
        activation = sigmoid_lut[8'((acc + SUM_LIM) >> 20)];
      end
      default: ;
    endcase
    r.neuron_out = activation;
    return r;
  endfunction

  task automatic log_failure(input string msg);
    fail_total++;
    if (fail_total <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // retire result words against the oldest prediction, then queue new ones
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          log_failure($sformatf("unexpected result word: out %0d status %0d",
                                result.neuron_out, result.status));
        end else begin
          want = expected_q.pop_front();
          if (want.neuron_out !== result.neuron_out || want.status !== result.status)
            log_failure($sformatf("result word mismatch: expected out %0d status %0d, got out %0d status %0d",
                                  want.neuron_out, want.status,
                                  result.neuron_out, result.status));
        end
      end
      if (item_valid && !item_stall) expected_q = {expected_q, neuron_step(item)};
      mismatches  <= fail_total;
      outstanding <= expected_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb import snct_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 64;
  localparam int PHASE_WORDS  = 445;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 120;
  localparam int LIMIT        = 1000000;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_word_t  item;
  logic      result_valid;
  logic      result_stall;
  out_word_t result;
  logic      hold_req;
  int        idle_pct;
  int        stall_pct;
  int        mismatches;
  int        outstanding;
  int        cycle_count = 0;
  logic [15:0] used_src [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sigmoid_neuron_connection_table #(.MAX_CONNECTIONS(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  snct_predict_check #(.DEPTH(DEPTH)) u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall, plus one long hold-off on request
  initial begin
    bit held_once;
    held_once    = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        repeat (HOLD_CYCLES) begin
          result_stall <= 1'b1;
          @(posedge clk);
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_word_t make_word(input func_t f, input logic [7:0] x,
                                         input logic [7:0] y, input logic signed [15:0] v);
    in_word_t w;
    w.func  = f;
    w.src_x = x;
    w.src_y = y;
    w.value = v;
    return w;
  endfunction

  // offer one word after a random idle gap and wait until it is taken
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    if (w.func == FUNC_LOAD) used_src = {used_src, {w.src_x, w.src_y}};
    do @(posedge clk); while (item_stall);
  endtask

  // random words: mostly deliveries to known sources and computes
  task automatic run_phase(input int idle, input int stall, input bit with_hold);
    in_word_t w;
    int       sel;
    idle_pct = idle;
    stall_pct <= stall;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (with_hold && i == 60) hold_req <= 1'b1;
      sel     = $urandom_range(99);
      w.src_x = 8'($urandom);
      w.src_y = 8'($urandom);
      case ($urandom_range(7))
        0: w.value = 16'($urandom);
        1: begin
          case ($urandom_range(4))
            0: w.value = 16'sh8000;
            1: w.value = 16'sh7FFF;
            2: w.value = 16'sh0000;
            3: w.value = 16'sh0001;
            default: w.value = 16'shFFFF;
          endcase
        end
        2, 3, 4: w.value = 16'(int'($urandom_range(4095)) - 2048);
        default: w.value = 16'(int'($urandom_range(255)) - 128);
      endcase
      if (sel < 12) begin
        w.func = FUNC_LOAD;
        if (used_src.size() != 0 && $urandom_range(1) == 0)
          {w.src_x, w.src_y} = used_src[$urandom_range(used_src.size() - 1)];
      end else if (sel < 62) begin
        w.func = FUNC_DELIVER;
        if (used_src.size() != 0 && $urandom_range(4) != 0)
          {w.src_x, w.src_y} = used_src[$urandom_range(used_src.size() - 1)];
      end else if (sel < 96) begin
        w.func = FUNC_COMPUTE;
      end else begin
        w.func = FUNC_NOP;
      end
      send_word(w);
    end
    // sender pauses until every result word is back
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    hold_req   = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, unused code, loads and sum corner cases
    send_word(make_word(FUNC_COMPUTE, 8'hA5, 8'h5A, 16'sh7FFF));
    send_word(make_word(FUNC_NOP, 8'hFF, 8'hFF, 16'shFFFF));
    send_word(make_word(FUNC_DELIVER, 8'h00, 8'h00, 16'sh1000));
    send_word(make_word(FUNC_LOAD, 8'h00, 8'h00, 16'sh7FFF));
    send_word(make_word(FUNC_LOAD, 8'hFF, 8'hFF, 16'sh8000));
    send_word(make_word(FUNC_LOAD, 8'h00, 8'h00, 16'sh1000));
    send_word(make_word(FUNC_LOAD, 8'h12, 8'h34, 16'shFFFF));
    send_word(make_word(FUNC_COMPUTE, 8'h00, 8'h00, 16'sh0000));
    // saturation high
    send_word(make_word(FUNC_DELIVER, 8'h00, 8'h00, 16'sh7FFF));
    send_word(make_word(FUNC_COMPUTE, 8'h00, 8'h00, 16'sh0000));
    // saturation low
    send_word(make_word(FUNC_DELIVER, 8'h00, 8'h00, 16'sh0000));
    send_word(make_word(FUNC_DELIVER, 8'hFF, 8'hFF, 16'sh7FFF));
    send_word(make_word(FUNC_COMPUTE, 8'h00, 8'h00, 16'sh0000));
    // small positive sum lands on the midpoint entry
    send_word(make_word(FUNC_DELIVER, 8'hFF, 8'hFF, 16'sh0000));
    send_word(make_word(FUNC_DELIVER, 8'h00, 8'h00, 16'sh0008));
    send_word(make_word(FUNC_COMPUTE, 8'h00, 8'h00, 16'sh0000));
    // small negative sum rounds down to the entry below
    send_word(make_word(FUNC_DELIVER, 8'h00, 8'h00, -16'sd8));
    send_word(make_word(FUNC_COMPUTE, 8'h00, 8'h00, 16'sh0000));
    send_word(make_word(FUNC_DELIVER, 8'h12, 8'h34, 16'sh8000));
    send_word(make_word(FUNC_DELIVER, 8'h99, 8'h99, 16'sh04D2));
    send_word(make_word(FUNC_COMPUTE, 8'h00, 8'h00, 16'sh0000));

    // random phases with different idle and stall mixes
    run_phase(0, 0, 1'b1);
    run_phase(51, 0, 1'b0);
    run_phase(0, 51, 1'b0);
    run_phase(26, 26, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sigmoid_neuron_connection_table.f =====
hw/rtl/snct_pkg.sv
hw/rtl/snct_ram.sv
hw/rtl/snct_mac.sv
hw/rtl/sigmoid_neuron_connection_table.sv
verif/snct_predict_check.sv
verif/tb.sv
